@@ rtl/eu2x_pkg.sv @@
// shared types, widths and constants for the edge-directed 2x upscaler
package eu2x_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int INDEX_W = 8;
  localparam int COLOR_W = 15;
  localparam int ROW_OUT_W = 10;
  localparam int COL_OUT_W = 9;

  localparam int WIDTH_REG_W  = 10;
  localparam int HEIGHT_REG_W = 11;
  localparam int MASK_REG_W   = 15;
  localparam int CFG_DATA_W   = 15;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 10'd320;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 11'd240;
  localparam logic [MASK_REG_W-1:0]   MASK_RESET   = 15'h739C;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MASK   = 2'd2;

  // input item kinds
  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_PIXEL   = 1'b1;

  localparam int PAL_DEPTH = 256;
  localparam int NUM_TAPS  = 8;

  // palette read taps, one per compared neighbor
  localparam int TAP_UL = 0;
  localparam int TAP_L  = 1;
  localparam int TAP_DL = 2;
  localparam int TAP_U  = 3;
  localparam int TAP_D  = 4;
  localparam int TAP_UR = 5;
  localparam int TAP_R  = 6;
  localparam int TAP_DR = 7;

  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [COLOR_W-1:0] color_t;

  typedef struct packed {
    logic   en;
    index_t addr;
    color_t color;
  } pal_write_t;

endpackage

@@ rtl/eu2x_if.sv @@
// valid/ready channels for source items and output blocks
interface eu2x_in_if;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  eu2x_pkg::index_t     pixel_index;
  eu2x_pkg::index_t     entry_number;
  eu2x_pkg::color_t     entry_color;

  modport source (output valid, kind, pixel_index, entry_number, entry_color, input ready);
  modport sink   (input valid, kind, pixel_index, entry_number, entry_color, output ready);
endinterface

interface eu2x_out_if;
  logic                                valid;
  logic                                ready;
  logic [eu2x_pkg::ROW_OUT_W-1:0]      center_row;
  logic [eu2x_pkg::COL_OUT_W-1:0]      center_col;
  eu2x_pkg::index_t                    out_top_left;
  eu2x_pkg::index_t                    out_top_right;
  eu2x_pkg::index_t                    out_bottom_left;
  eu2x_pkg::index_t                    out_bottom_right;
  logic                                frame_done;

  modport source (output valid, center_row, center_col, out_top_left, out_top_right,
                  out_bottom_left, out_bottom_right, frame_done, input ready);
  modport sink   (input valid, center_row, center_col, out_top_left, out_top_right,
                  out_bottom_left, out_bottom_right, frame_done, output ready);
endinterface

@@ rtl/edge_directed_2x_upscaler.sv @@
// edge-directed 2x upscaler top level: line buffers, window and corner rule
//
//   channel      dir  handshake          payload
//   pixel_in     in   valid/ready        kind, pixel_index, entry_number, entry_color
//   block_out    out  valid/ready        center_row, center_col, four corner indexes,
//                                        frame_done
//   write_*      in   write_enable only  write_index, write_data
//
// one item per cycle; after its item is accepted, a pixel result passes through the line
// buffer read, the palette read and the compare into the output register.
// the two stages and the output register advance together whenever the output
// register is empty or being taken, so a stall on block_out holds pixel_in.ready low.
// rst clears valids, counters, window and configuration; memories are not cleared.
module edge_directed_2x_upscaler #(
  parameter int MAX_WIDTH  = eu2x_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = eu2x_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  eu2x_in_if.sink                              pixel_in,
  eu2x_out_if.source                           block_out,
  input  logic                                 write_enable,
  input  logic [eu2x_pkg::CFG_INDEX_W-1:0]     write_index,
  input  logic [eu2x_pkg::CFG_DATA_W-1:0]      write_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WCMP  = (COL_W + 1 > eu2x_pkg::WIDTH_REG_W) ? COL_W + 1
                                                               : eu2x_pkg::WIDTH_REG_W;
  localparam int HCMP  = (ROW_W + 1 > eu2x_pkg::HEIGHT_REG_W) ? ROW_W + 1
                                                                : eu2x_pkg::HEIGHT_REG_W;
  localparam int RX    = (ROW_W > eu2x_pkg::ROW_OUT_W) ? ROW_W : eu2x_pkg::ROW_OUT_W;
  localparam int CX    = (COL_W > eu2x_pkg::COL_OUT_W) ? COL_W : eu2x_pkg::COL_OUT_W;
  localparam int LB_W  = 2 * eu2x_pkg::INDEX_W;

  // configuration
  logic [eu2x_pkg::WIDTH_REG_W-1:0]  frame_width;
  logic [eu2x_pkg::HEIGHT_REG_W-1:0] frame_height;
  logic [eu2x_pkg::MASK_REG_W-1:0]   color_mask;

  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;

  logic [WCMP-1:0] width_ext;
  logic [WCMP-1:0] width_eff;
  logic [HCMP-1:0] height_ext;
  logic [HCMP-1:0] height_eff;
  logic            col_last;
  logic            row_last;

  logic adv;
  logic accept;
  logic accept_pixel;

  // stage 1: line buffer read data and item fields
  logic [LB_W-1:0]         line_buf [MAX_WIDTH];
  logic [LB_W-1:0]         lb_rd;
  logic                    s1_valid;
  logic                    s1_kind;
  eu2x_pkg::index_t        s1_bot;
  eu2x_pkg::index_t        s1_entry;
  eu2x_pkg::color_t        s1_color;
  logic [COL_W-1:0]        s1_col;
  logic                    s1_produce;
  logic                    s1_done;
  logic [eu2x_pkg::ROW_OUT_W-1:0] s1_row_out;
  logic [eu2x_pkg::COL_OUT_W-1:0] s1_col_out;
  eu2x_pkg::index_t        s1_top;
  eu2x_pkg::index_t        s1_mid;
  logic                    s1_pix;

  logic [RX-1:0] row_minus;
  logic [CX-1:0] col_minus;

  // 3x3 window, two older columns
  eu2x_pkg::index_t win_ul, win_l, win_dl, win_u, win_c, win_d;

  // stage 2: palette colors arrive registered
  eu2x_pkg::pal_write_t pal_wr;
  eu2x_pkg::index_t     pal_addr  [eu2x_pkg::NUM_TAPS];
  eu2x_pkg::color_t     pal_color [eu2x_pkg::NUM_TAPS];
  logic                 s2_valid;
  eu2x_pkg::index_t     s2_u, s2_c, s2_ur, s2_dl, s2_d;
  logic                 s2_done;
  logic [eu2x_pkg::ROW_OUT_W-1:0] s2_row_out;
  logic [eu2x_pkg::COL_OUT_W-1:0] s2_col_out;

  eu2x_pkg::color_t m_ul, m_l, m_dl, m_u, m_d, m_ur, m_r, m_dr;
  logic             flat;
  eu2x_pkg::index_t tl_next, tr_next, bl_next, br_next;

  // output register
  logic             out_valid;
  logic [eu2x_pkg::ROW_OUT_W-1:0] out_row;
  logic [eu2x_pkg::COL_OUT_W-1:0] out_col;
  eu2x_pkg::index_t out_tl, out_tr, out_bl, out_br;
  logic             out_done;

  assign adv          = !out_valid || block_out.ready;
  assign accept       = adv && pixel_in.valid;
  assign accept_pixel = accept && (pixel_in.kind == eu2x_pkg::KIND_PIXEL);
  assign pixel_in.ready = adv;

  // sizes saturated to the supported range
  always_comb begin
    width_ext  = WCMP'(frame_width);
    height_ext = HCMP'(frame_height);
    priority if (width_ext < WCMP'(3)) begin
      width_eff = WCMP'(3);
    end else if (width_ext > WCMP'(MAX_WIDTH)) begin
      width_eff = WCMP'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    priority if (height_ext < HCMP'(3)) begin
      height_eff = HCMP'(3);
    end else if (height_ext > HCMP'(MAX_HEIGHT)) begin
      height_eff = HCMP'(MAX_HEIGHT);
    end else begin
      height_eff = height_ext;
    end
  end

  assign col_last  = (WCMP'(col_count) + WCMP'(1)) >= width_eff;
  assign row_last  = (HCMP'(row_count) + HCMP'(1)) >= height_eff;
  assign row_minus = RX'(row_count) - RX'(1);
  assign col_minus = CX'(col_count) - CX'(1);

  // configuration and raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= eu2x_pkg::WIDTH_RESET;
      frame_height <= eu2x_pkg::HEIGHT_RESET;
      color_mask   <= eu2x_pkg::MASK_RESET;
      col_count    <= '0;
      row_count    <= '0;
    end else begin
      if (accept_pixel) begin
        if (col_last) begin
          col_count <= '0;
          row_count <= row_last ? '0 : row_count + ROW_W'(1);
        end else begin
          col_count <= col_count + COL_W'(1);
        end
      end
      if (write_enable) begin
        unique case (write_index)
          eu2x_pkg::REG_FRAME_WIDTH: begin
            frame_width <= write_data[eu2x_pkg::WIDTH_REG_W-1:0];
            col_count   <= '0;
            row_count   <= '0;
          end
          eu2x_pkg::REG_FRAME_HEIGHT: begin
            frame_height <= write_data[eu2x_pkg::HEIGHT_REG_W-1:0];
            col_count    <= '0;
            row_count    <= '0;
          end
          eu2x_pkg::REG_COLOR_MASK: begin
            color_mask <= write_data[eu2x_pkg::MASK_REG_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // line buffers as one {older, newer} pair per column
  assign s1_pix = s1_valid && (s1_kind == eu2x_pkg::KIND_PIXEL);
  assign s1_top = lb_rd[LB_W-1:eu2x_pkg::INDEX_W];
  assign s1_mid = lb_rd[eu2x_pkg::INDEX_W-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      lb_rd <= line_buf[col_count];
    end
  end

  // write-back leaves stage 1 before the same column is read again (width >= 3)
  always_ff @(posedge clk) begin
    if (adv && s1_pix) begin
      line_buf[s1_col] <= {s1_mid, s1_bot};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pixel_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind    <= pixel_in.kind;
      s1_bot     <= pixel_in.pixel_index;
      s1_entry   <= pixel_in.entry_number;
      s1_color   <= pixel_in.entry_color;
      s1_col     <= col_count;
      s1_produce <= (row_count >= ROW_W'(2)) && (col_count >= COL_W'(2));
      s1_done    <= row_last && col_last;
      s1_row_out <= row_minus[eu2x_pkg::ROW_OUT_W-1:0];
      s1_col_out <= col_minus[eu2x_pkg::COL_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_ul <= '0;
      win_l  <= '0;
      win_dl <= '0;
      win_u  <= '0;
      win_c  <= '0;
      win_d  <= '0;
    end else if (adv && s1_pix) begin
      win_ul <= win_u;
      win_l  <= win_c;
      win_dl <= win_d;
      win_u  <= s1_top;
      win_c  <= s1_mid;
      win_d  <= s1_bot;
    end
  end

  // palette writes and reads both happen in stage 1, in item order
  always_comb begin
    pal_wr.en    = adv && s1_valid && (s1_kind == eu2x_pkg::KIND_PALETTE);
    pal_wr.addr  = s1_entry;
    pal_wr.color = s1_color;
    pal_addr[eu2x_pkg::TAP_UL] = win_ul;
    pal_addr[eu2x_pkg::TAP_L]  = win_l;
    pal_addr[eu2x_pkg::TAP_DL] = win_dl;
    pal_addr[eu2x_pkg::TAP_U]  = win_u;
    pal_addr[eu2x_pkg::TAP_D]  = win_d;
    pal_addr[eu2x_pkg::TAP_UR] = s1_top;
    pal_addr[eu2x_pkg::TAP_R]  = s1_mid;
    pal_addr[eu2x_pkg::TAP_DR] = s1_bot;
  end

  eu2x_palette u_palette (
    .clk        (clk),
    .wr         (pal_wr),
    .read_en    (adv),
    .read_addr  (pal_addr),
    .read_color (pal_color)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_pix && s1_produce;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_u       <= win_u;
      s2_c       <= win_c;
      s2_ur      <= s1_top;
      s2_dl      <= win_dl;
      s2_d       <= win_d;
      s2_done    <= s1_done;
      s2_row_out <= s1_row_out;
      s2_col_out <= s1_col_out;
    end
  end

  // corner rule on masked colors
  always_comb begin
    m_ul = pal_color[eu2x_pkg::TAP_UL] & color_mask;
    m_l  = pal_color[eu2x_pkg::TAP_L]  & color_mask;
    m_dl = pal_color[eu2x_pkg::TAP_DL] & color_mask;
    m_u  = pal_color[eu2x_pkg::TAP_U]  & color_mask;
    m_d  = pal_color[eu2x_pkg::TAP_D]  & color_mask;
    m_ur = pal_color[eu2x_pkg::TAP_UR] & color_mask;
    m_r  = pal_color[eu2x_pkg::TAP_R]  & color_mask;
    m_dr = pal_color[eu2x_pkg::TAP_DR] & color_mask;
    flat = (m_u == m_d) && (m_u == m_l) && (m_u == m_r);
    tl_next = (!flat && m_ul == m_l && m_ul == m_u) ? s2_u  : s2_c;
    tr_next = (!flat && m_ur == m_r && m_ur == m_u) ? s2_ur : s2_c;
    bl_next = (!flat && m_dl == m_l && m_dl == m_d) ? s2_dl : s2_c;
    br_next = (!flat && m_dr == m_r && m_dr == m_d) ? s2_d  : s2_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_row  <= s2_row_out;
      out_col  <= s2_col_out;
      out_tl   <= tl_next;
      out_tr   <= tr_next;
      out_bl   <= bl_next;
      out_br   <= br_next;
      out_done <= s2_done;
    end
  end

  assign block_out.valid            = out_valid;
  assign block_out.center_row       = out_row;
  assign block_out.center_col       = out_col;
  assign block_out.out_top_left     = out_tl;
  assign block_out.out_top_right    = out_tr;
  assign block_out.out_bottom_left  = out_bl;
  assign block_out.out_bottom_right = out_br;
  assign block_out.frame_done       = out_done;

endmodule

@@ rtl/eu2x_palette.sv @@
// palette table: replicated copies give eight registered reads per cycle while read_en is high
module eu2x_palette (
  input  logic                    clk,
  input  eu2x_pkg::pal_write_t    wr,
  input  logic                    read_en,
  input  eu2x_pkg::index_t        read_addr  [eu2x_pkg::NUM_TAPS],
  output eu2x_pkg::color_t        read_color [eu2x_pkg::NUM_TAPS]
);

  genvar g;
  generate
    for (g = 0; g < eu2x_pkg::NUM_TAPS / 2; g++) begin : g_copy
      eu2x_pkg::color_t mem [eu2x_pkg::PAL_DEPTH];
      eu2x_pkg::color_t rd_a;
      eu2x_pkg::color_t rd_b;

      // every copy takes every write so all copies stay identical
      always_ff @(posedge clk) begin
        if (wr.en) begin
          mem[wr.addr] <= wr.color;
        end
      end

      always_ff @(posedge clk) begin
        if (read_en) begin
          rd_a <= mem[read_addr[2*g]];
          rd_b <= mem[read_addr[2*g+1]];
        end
      end

      assign read_color[2*g]   = rd_a;
      assign read_color[2*g+1] = rd_b;
    end
  endgenerate

endmodule
